[sv/vfc_pkg.sv]
// ----------------------------------------------------------------------------
// vfc_pkg
// Shared types and constants of the voxel face culling mesher.
// ----------------------------------------------------------------------------
package vfc_pkg;

    // Command codes of the input transaction
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_EVAL  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // Read slots of one evaluation: center first, then the six neighbors
    // in face order.
    localparam int          NUM_FACES = 6;
    localparam int          NUM_RD    = NUM_FACES + 1;
    localparam logic [2:0]  RD_CENTER = 3'd0;
    localparam logic [2:0]  RD_NEG_X  = 3'd1;
    localparam logic [2:0]  RD_POS_X  = 3'd2;
    localparam logic [2:0]  RD_NEG_Z  = 3'd3;
    localparam logic [2:0]  RD_POS_Z  = 3'd4;
    localparam logic [2:0]  RD_NEG_Y  = 3'd5;
    localparam logic [2:0]  RD_POS_Y  = 3'd6;

    // Face directions as carried in face_dir
    localparam int FACE_DOWN = 4;
    localparam int FACE_UP   = 5;

    // Face counter and vertex index
    localparam int COUNT_W     = 17;
    localparam int VERT_SHIFT  = 2;   // four vertices per face
    localparam int VERT_BASE_W = COUNT_W + VERT_SHIFT;

    // Output field widths
    localparam int VX_W = 4;
    localparam int VY_W = 6;
    localparam int VZ_W = 4;
    localparam int DIR_W = 3;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_READ,
        SEQ_DRAIN,
        SEQ_HAND
    } t_seq_state;

    // Work handed from the sequencer to the face emitter
    typedef struct packed {
        logic                  clear;
        logic [NUM_FACES-1:0]  mask;
        logic [VX_W-1:0]       vx;
        logic [VY_W-1:0]       vy;
        logic [VZ_W-1:0]       vz;
    } t_job;

endpackage

[sv/vfc_occ_mem.sv]
// ----------------------------------------------------------------------------
// vfc_occ_mem
// One-bit occupancy memory: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module vfc_occ_mem #(
    parameter int DEPTH = 20736,
    parameter int AW    = 15
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic          i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic          o_rd_data
);

    logic r_mem [DEPTH];
    logic r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[sv/vfc_seq.sv]
// ----------------------------------------------------------------------------
// vfc_seq
// Command sequencer: takes input transactions, writes occupancy, reads the
// center voxel and its six neighbors one per cycle, and hands face jobs on.
// ----------------------------------------------------------------------------
module vfc_seq #(
    parameter int CHUNK_SIDE   = 16,
    parameter int CHUNK_LAYERS = 64,
    parameter int AW           = 15
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    // input channel
    input  logic            i_valid,
    output logic            o_stall,
    input  logic [1:0]      i_command,
    input  logic [4:0]      i_pos_x,
    input  logic [5:0]      i_pos_y,
    input  logic [4:0]      i_pos_z,
    input  logic            i_solid,
    // memory
    output logic            o_wr_en,
    output logic [AW-1:0]   o_wr_addr,
    output logic            o_wr_data,
    output logic            o_rd_en,
    output logic [AW-1:0]   o_rd_addr,
    input  logic            i_rd_data,
    // job handoff
    output logic            o_job_valid,
    output vfc_pkg::t_job   o_job,
    input  logic            i_job_ready
);

    localparam int PADDED = CHUNK_SIDE + 2;
    localparam int PLANE  = PADDED * PADDED;

    vfc_pkg::t_seq_state r_state, n_state;

    logic [AW-1:0]              r_addr;
    logic [2:0]                 r_step;
    logic                       r_rd_pend;
    logic [2:0]                 r_rd_idx;
    logic [vfc_pkg::NUM_RD-1:0] r_solid;
    logic                       r_clear;
    logic                       r_bottom;
    logic                       r_top;
    logic [vfc_pkg::VX_W-1:0]   r_vx;
    logic [vfc_pkg::VY_W-1:0]   r_vy;
    logic [vfc_pkg::VZ_W-1:0]   r_vz;

    logic                          accept;
    logic                          in_store;
    logic                          in_interior;
    logic [AW-1:0]                 in_addr;
    logic [vfc_pkg::NUM_FACES-1:0] exposed;
    logic                          job_live;
    logic                          rd_en;
    logic [AW-1:0]                 rd_addr;

    assign accept = i_valid && !o_stall;

    assign in_store = (int'(i_pos_x) < PADDED) && (int'(i_pos_z) < PADDED)
                   && (int'(i_pos_y) < CHUNK_LAYERS);
    assign in_interior = (i_pos_x != 5'd0) && (int'(i_pos_x) <= CHUNK_SIDE)
                      && (i_pos_z != 5'd0) && (int'(i_pos_z) <= CHUNK_SIDE)
                      && (int'(i_pos_y) < CHUNK_LAYERS);

    // Linear address: layer-major, then z, then x
    assign in_addr = AW'(int'(i_pos_y) * PLANE + int'(i_pos_z) * PADDED + int'(i_pos_x));

    assign o_wr_en   = accept && (i_command == vfc_pkg::CMD_WRITE) && in_store;
    assign o_wr_addr = in_addr;
    assign o_wr_data = i_solid;

    // Exposure from the captured reads; layer bounds always show.
    always_comb begin
        for (int d = 0; d < vfc_pkg::NUM_FACES; d++) begin
            exposed[d] = !r_solid[d + 1];
        end
        if (r_bottom) begin
            exposed[vfc_pkg::FACE_DOWN] = 1'b1;
        end
        if (r_top) begin
            exposed[vfc_pkg::FACE_UP] = 1'b1;
        end
    end

    assign job_live = r_clear || (r_solid[vfc_pkg::RD_CENTER] && (exposed != '0));

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            vfc_pkg::SEQ_IDLE: begin
                if (accept) begin
                    if (i_command == vfc_pkg::CMD_CLEAR) begin
                        n_state = vfc_pkg::SEQ_HAND;
                    end else if (i_command == vfc_pkg::CMD_EVAL && in_interior) begin
                        n_state = vfc_pkg::SEQ_READ;
                    end
                end
            end
            vfc_pkg::SEQ_READ: begin
                if (r_step == vfc_pkg::RD_POS_Y) begin
                    n_state = vfc_pkg::SEQ_DRAIN;
                end
            end
            vfc_pkg::SEQ_DRAIN: begin
                n_state = vfc_pkg::SEQ_HAND;
            end
            vfc_pkg::SEQ_HAND: begin
                if (!job_live || i_job_ready) begin
                    n_state = vfc_pkg::SEQ_IDLE;
                end
            end
            default: n_state = vfc_pkg::SEQ_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_stall     = 1'b1;
        rd_en       = 1'b0;
        o_job_valid = 1'b0;
        unique case (r_state)
            vfc_pkg::SEQ_IDLE:  o_stall = 1'b0;
            vfc_pkg::SEQ_READ:  rd_en = 1'b1;
            vfc_pkg::SEQ_DRAIN: rd_en = 1'b0;
            vfc_pkg::SEQ_HAND:  o_job_valid = job_live;
            default:            o_stall = 1'b1;
        endcase
    end

    // Neighbor address; a missing layer neighbor rereads the center.
    always_comb begin
        unique case (r_step)
            vfc_pkg::RD_CENTER: rd_addr = r_addr;
            vfc_pkg::RD_NEG_X:  rd_addr = r_addr - AW'(1);
            vfc_pkg::RD_POS_X:  rd_addr = r_addr + AW'(1);
            vfc_pkg::RD_NEG_Z:  rd_addr = r_addr - AW'(PADDED);
            vfc_pkg::RD_POS_Z:  rd_addr = r_addr + AW'(PADDED);
            vfc_pkg::RD_NEG_Y:  rd_addr = r_bottom ? r_addr : r_addr - AW'(PLANE);
            vfc_pkg::RD_POS_Y:  rd_addr = r_top ? r_addr : r_addr + AW'(PLANE);
            default:            rd_addr = r_addr;
        endcase
    end

    assign o_rd_en   = rd_en;
    assign o_rd_addr = rd_addr;

    assign o_job.clear = r_clear;
    assign o_job.mask  = r_clear ? '0 : exposed;
    assign o_job.vx    = r_vx;
    assign o_job.vy    = r_vy;
    assign o_job.vz    = r_vz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= vfc_pkg::SEQ_IDLE;
            r_step    <= vfc_pkg::RD_CENTER;
            r_rd_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= rd_en;
            if (rd_en) begin
                r_step <= r_step + 3'd1;
            end else if (r_state == vfc_pkg::SEQ_IDLE) begin
                r_step <= vfc_pkg::RD_CENTER;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_step;
        if (r_rd_pend) begin
            r_solid[r_rd_idx] <= i_rd_data;
        end
        if (accept) begin
            r_addr   <= in_addr;
            r_clear  <= (i_command == vfc_pkg::CMD_CLEAR);
            r_bottom <= (i_pos_y == '0);
            r_top    <= (int'(i_pos_y) == CHUNK_LAYERS - 1);
            r_vx     <= vfc_pkg::VX_W'(i_pos_x - 5'd1);
            r_vy     <= i_pos_y;
            r_vz     <= vfc_pkg::VZ_W'(i_pos_z - 5'd1);
        end
    end

endmodule

[sv/vfc_emit.sv]
// ----------------------------------------------------------------------------
// vfc_emit
// Face emitter: walks the exposed-face mask in face order, numbers faces
// with the running counter and drives the registered output channel.
// ----------------------------------------------------------------------------
module vfc_emit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_job_valid,
    input  vfc_pkg::t_job                     i_job,
    output logic                              o_job_ready,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [vfc_pkg::VX_W-1:0]          o_voxel_x,
    output logic [vfc_pkg::VY_W-1:0]          o_voxel_y,
    output logic [vfc_pkg::VZ_W-1:0]          o_voxel_z,
    output logic [vfc_pkg::DIR_W-1:0]         o_face_dir,
    output logic [vfc_pkg::VERT_BASE_W-1:0]   o_vertex_base,
    output logic                              o_last_face
);

    logic [vfc_pkg::NUM_FACES-1:0] r_mask;
    logic [vfc_pkg::VX_W-1:0]      r_vx;
    logic [vfc_pkg::VY_W-1:0]      r_vy;
    logic [vfc_pkg::VZ_W-1:0]      r_vz;
    logic [vfc_pkg::COUNT_W-1:0]   r_count;

    logic                              r_valid;
    logic [vfc_pkg::VX_W-1:0]          r_out_x;
    logic [vfc_pkg::VY_W-1:0]          r_out_y;
    logic [vfc_pkg::VZ_W-1:0]          r_out_z;
    logic [vfc_pkg::DIR_W-1:0]         r_out_dir;
    logic [vfc_pkg::VERT_BASE_W-1:0]   r_out_base;
    logic                              r_out_last;

    logic                          out_free;
    logic                          load;
    logic [vfc_pkg::DIR_W-1:0]     pick;
    logic [vfc_pkg::NUM_FACES-1:0] rest;
    logic                          job_take;

    assign out_free    = !r_valid || !i_stall;
    assign load        = out_free && (r_mask != '0);
    assign o_job_ready = (r_mask == '0);
    assign job_take    = i_job_valid && o_job_ready;

    // Lowest pending face first
    always_comb begin
        logic found;
        found = 1'b0;
        pick  = '0;
        rest  = r_mask;
        for (int d = 0; d < vfc_pkg::NUM_FACES; d++) begin
            if (!found && r_mask[d]) begin
                found   = 1'b1;
                pick    = vfc_pkg::DIR_W'(d);
                rest[d] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask  <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_mask  <= rest;
                r_count <= r_count + vfc_pkg::COUNT_W'(1);
            end else begin
                if (out_free) begin
                    r_valid <= 1'b0;
                end
                if (job_take) begin
                    r_mask <= i_job.mask;
                    if (i_job.clear) begin
                        r_count <= '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (job_take) begin
            r_vx <= i_job.vx;
            r_vy <= i_job.vy;
            r_vz <= i_job.vz;
        end
        if (load) begin
            r_out_x    <= r_vx;
            r_out_y    <= r_vy;
            r_out_z    <= r_vz;
            r_out_dir  <= pick;
            r_out_base <= vfc_pkg::VERT_BASE_W'(r_count) << vfc_pkg::VERT_SHIFT;
            r_out_last <= (rest == '0);
        end
    end

    assign o_valid       = r_valid;
    assign o_voxel_x     = r_out_x;
    assign o_voxel_y     = r_out_y;
    assign o_voxel_z     = r_out_z;
    assign o_face_dir    = r_out_dir;
    assign o_vertex_base = r_out_base;
    assign o_last_face   = r_out_last;

endmodule

[sv/voxel_face_culling_mesher_core.sv]
// ----------------------------------------------------------------------------
// voxel_face_culling_mesher_core
// Keeps the occupancy of one padded chunk and emits one result per exposed
// face of an evaluated voxel, numbered by a running face counter. A write
// leaves the input free; a clear or an evaluate holds it until handed on.
// An evaluate reads the center voxel and its six neighbors through the
// single read port, one per cycle; the faces (up to six, one per cycle while
// the output is not stalled) then leave from the output register while the
// next transaction is taken. The memory needs no clearing pass if the user
// writes every voxel before it is evaluated; the block does not enforce it.
// ----------------------------------------------------------------------------
module voxel_face_culling_mesher_core #(
    parameter int CHUNK_SIDE   = 16,
    parameter int CHUNK_LAYERS = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [1:0]                        i_command,
    input  logic [4:0]                        i_pos_x,
    input  logic [5:0]                        i_pos_y,
    input  logic [4:0]                        i_pos_z,
    input  logic                              i_solid,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [vfc_pkg::VX_W-1:0]          o_voxel_x,
    output logic [vfc_pkg::VY_W-1:0]          o_voxel_y,
    output logic [vfc_pkg::VZ_W-1:0]          o_voxel_z,
    output logic [vfc_pkg::DIR_W-1:0]         o_face_dir,
    output logic [vfc_pkg::VERT_BASE_W-1:0]   o_vertex_base,
    output logic                              o_last_face
);

    localparam int PADDED = CHUNK_SIDE + 2;
    localparam int DEPTH  = PADDED * PADDED * CHUNK_LAYERS;
    localparam int AW     = $clog2(DEPTH);

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          rd_data;
    logic          job_valid;
    logic          job_ready;
    vfc_pkg::t_job job;

    vfc_occ_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    vfc_seq #(
        .CHUNK_SIDE   (CHUNK_SIDE),
        .CHUNK_LAYERS (CHUNK_LAYERS),
        .AW           (AW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_command   (i_command),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_pos_z     (i_pos_z),
        .i_solid     (i_solid),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_job_valid (job_valid),
        .o_job       (job),
        .i_job_ready (job_ready)
    );

    vfc_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (job_valid),
        .i_job         (job),
        .o_job_ready   (job_ready),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_voxel_x     (o_voxel_x),
        .o_voxel_y     (o_voxel_y),
        .o_voxel_z     (o_voxel_z),
        .o_face_dir    (o_face_dir),
        .o_vertex_base (o_vertex_base),
        .o_last_face   (o_last_face)
    );

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for voxel_face_culling_mesher_core. A scoreboard keeps
// its own copy of the padded occupancy and the face counter. Every accepted
// command updates that copy and queues the faces it should produce. Every face
// leaving the core is checked against the oldest queued one. Stimulus is a
// short directed list followed by random writes, clears, unused commands,
// neighborhood fills and evaluates. Both sides idle and stall at random,
// and the output is held off for a long stretch once.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int SIDE   = 16;
    localparam int LAYERS = 64;
    localparam int PAD    = SIDE + 2;

    localparam logic [1:0] CMD_NONE = 2'd3;   // unused code, must be ignored

    localparam int LIMIT      = 1_000_000;
    localparam int DRAIN_TAIL = 30;
    localparam int HOLD_LEN   = 300;
    localparam int MAX_SHOWN  = 10;

    typedef struct packed {
        logic [vfc_pkg::VX_W-1:0]        vx;
        logic [vfc_pkg::VY_W-1:0]        vy;
        logic [vfc_pkg::VZ_W-1:0]        vz;
        logic [vfc_pkg::DIR_W-1:0]       dir;
        logic [vfc_pkg::VERT_BASE_W-1:0] vbase;
        logic                            last;
    } t_face;

    function automatic bit in_store(input int x, input int y, input int z);
        return x >= 0 && x < PAD && y >= 0 && y < LAYERS && z >= 0 && z < PAD;
    endfunction

    // Cell k of an evaluation window: the center, then the six neighbors
    function automatic void window_cell(input int k, input int x, input int y, input int z,
                                        output int nx, output int ny, output int nz);
        nx = x;
        ny = y;
        nz = z;
        case (3'(k))
            vfc_pkg::RD_NEG_X: nx = x - 1;
            vfc_pkg::RD_POS_X: nx = x + 1;
            vfc_pkg::RD_NEG_Z: nz = z - 1;
            vfc_pkg::RD_POS_Z: nz = z + 1;
            vfc_pkg::RD_NEG_Y: ny = y - 1;
            vfc_pkg::RD_POS_Y: ny = y + 1;
            default: ;
        endcase
    endfunction

    class mesh_checker;
        bit                          occ [PAD][LAYERS][PAD];
        logic [vfc_pkg::COUNT_W-1:0] face_count;
        t_face                       pending_faces[$];
        int                          fail_count;

        function new();
            face_count = '0;
            fail_count = 0;
        endfunction

        function bit solid_at(input int x, input int y, input int z);
            if (!in_store(x, y, z))
                return 1'b0;
            return occ[x][y][z];
        endfunction

        function void note_command(input logic [1:0] cmd, input logic [4:0] px,
                                   input logic [5:0] py, input logic [4:0] pz, input logic s);
            int                            x, y, z, last_dir;
            logic [vfc_pkg::NUM_FACES-1:0] open_faces;
            t_face                         f;
            x = px;
            y = py;
            z = pz;
            case (cmd)
                vfc_pkg::CMD_WRITE: begin
                    if (in_store(x, y, z))
                        occ[x][y][z] = s;
                end
                vfc_pkg::CMD_CLEAR: face_count = '0;
                vfc_pkg::CMD_EVAL: begin
                    if (x >= 1 && x <= SIDE && z >= 1 && z <= SIDE && solid_at(x, y, z)) begin
                        open_faces[0] = !solid_at(x - 1, y, z);
                        open_faces[1] = !solid_at(x + 1, y, z);
                        open_faces[2] = !solid_at(x, y, z - 1);
                        open_faces[3] = !solid_at(x, y, z + 1);
                        open_faces[vfc_pkg::FACE_DOWN] = (y == 0) || !solid_at(x, y - 1, z);
                        open_faces[vfc_pkg::FACE_UP]   = (y == LAYERS - 1)
                                                      || !solid_at(x, y + 1, z);
                        last_dir = -1;
                        for (int d = 0; d < vfc_pkg::NUM_FACES; d++)
                            if (open_faces[d])
                                last_dir = d;
                        for (int d = 0; d < vfc_pkg::NUM_FACES; d++) begin
                            if (open_faces[d]) begin
                                f.vx    = vfc_pkg::VX_W'(x - 1);
                                f.vy    = vfc_pkg::VY_W'(y);
                                f.vz    = vfc_pkg::VZ_W'(z - 1);
                                f.dir   = vfc_pkg::DIR_W'(d);
                                f.vbase = vfc_pkg::VERT_BASE_W'(face_count)
                                          << vfc_pkg::VERT_SHIFT;
                                f.last  = (d == last_dir);
                                pending_faces.insert(pending_faces.size(), f);
                                face_count = face_count + 1'b1;
                            end
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_face(input t_face got);
            t_face want;
            if (pending_faces.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_SHOWN)
                    $display("unexpected face: x=%0d y=%0d z=%0d dir=%0d base=%0d last=%0d",
                             got.vx, got.vy, got.vz, got.dir, got.vbase, got.last);
                return;
            end
            want = pending_faces.pop_front();
            if (got.vx !== want.vx || got.vy !== want.vy || got.vz !== want.vz ||
                got.dir !== want.dir || got.vbase !== want.vbase || got.last !== want.last) begin
                fail_count++;
                if (fail_count <= MAX_SHOWN) begin
                    $display("face mismatch: expected x=%0d y=%0d z=%0d dir=%0d base=%0d last=%0d",
                             want.vx, want.vy, want.vz, want.dir, want.vbase, want.last);
                    $display("               actual   x=%0d y=%0d z=%0d dir=%0d base=%0d last=%0d",
                             got.vx, got.vy, got.vz, got.dir, got.vbase, got.last);
                end
            end
        endfunction
    endclass

    logic                            i_clk     = 1'b0;
    logic                            i_rst_n   = 1'b0;
    logic                            i_valid   = 1'b0;
    logic [1:0]                      i_command = vfc_pkg::CMD_WRITE;
    logic [4:0]                      i_pos_x   = '0;
    logic [5:0]                      i_pos_y   = '0;
    logic [4:0]                      i_pos_z   = '0;
    logic                            i_solid   = 1'b0;
    logic                            i_stall   = 1'b0;
    logic                            o_stall;
    logic                            o_valid;
    logic [vfc_pkg::VX_W-1:0]        o_voxel_x;
    logic [vfc_pkg::VY_W-1:0]        o_voxel_y;
    logic [vfc_pkg::VZ_W-1:0]        o_voxel_z;
    logic [vfc_pkg::DIR_W-1:0]       o_face_dir;
    logic [vfc_pkg::VERT_BASE_W-1:0] o_vertex_base;
    logic                            o_last_face;

    mesh_checker mesh = new();
    bit          written [PAD][LAYERS][PAD];
    int          items_sent  = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    logic        hold_on     = 1'b0;
    int          cycles      = 0;

    voxel_face_culling_mesher_core #(
        .CHUNK_SIDE   (SIDE),
        .CHUNK_LAYERS (LAYERS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_command     (i_command),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pos_z       (i_pos_z),
        .i_solid       (i_solid),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_voxel_x     (o_voxel_x),
        .o_voxel_y     (o_voxel_y),
        .o_voxel_z     (o_voxel_z),
        .o_face_dir    (o_face_dir),
        .o_vertex_base (o_vertex_base),
        .o_last_face   (o_last_face)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Output side: check each transaction, then pick the next stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            mesh.check_face({o_voxel_x, o_voxel_y, o_voxel_z, o_face_dir,
                             o_vertex_base, o_last_face});
        i_stall <= hold_on || ($urandom_range(99) < rx_idle_pct);
    end

    // An evaluate must never touch a store cell that was not written yet
    function automatic bit eval_ok(input int x, input int y, input int z);
        int nx, ny, nz;
        for (int k = 0; k < vfc_pkg::NUM_RD; k++) begin
            window_cell(k, x, y, z, nx, ny, nz);
            if (in_store(nx, ny, nz) && !written[nx][ny][nz])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic send_cmd(input logic [1:0] cmd, input int x, input int y, input int z,
                            input bit s);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_command <= cmd;
        i_pos_x   <= 5'(x);
        i_pos_y   <= 6'(y);
        i_pos_z   <= 5'(z);
        i_solid   <= s;
        do @(posedge i_clk); while (o_stall);
        mesh.note_command(cmd, 5'(x), 6'(y), 5'(z), s);
        if (cmd == vfc_pkg::CMD_WRITE && in_store(x, y, z))
            written[x][y][z] = 1'b1;
        if (cmd != CMD_NONE && !(cmd == vfc_pkg::CMD_WRITE && !in_store(x, y, z)))
            items_sent++;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (mesh.pending_faces.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);
    endtask

    // Writes every unwritten cell of the window as empty
    task automatic fill_unwritten(input int x, input int y, input int z);
        int nx, ny, nz;
        for (int k = 0; k < vfc_pkg::NUM_RD; k++) begin
            window_cell(k, x, y, z, nx, ny, nz);
            if (in_store(nx, ny, nz) && !written[nx][ny][nz])
                send_cmd(vfc_pkg::CMD_WRITE, nx, ny, nz, 1'b0);
        end
    endtask

    // Interior position near the chunk edges, often in the bottom/top layers
    task automatic pick_hot(output int x, output int y, output int z);
        x = ($urandom_range(1) != 0) ? $urandom_range(4, 1) : $urandom_range(16, 13);
        z = ($urandom_range(1) != 0) ? $urandom_range(4, 1) : $urandom_range(16, 13);
        case ($urandom_range(2))
            0: y = $urandom_range(3, 0);
            1: y = $urandom_range(63, 60);
            default: y = $urandom_range(63, 0);
        endcase
    endtask

    task automatic random_step();
        int  r, x, y, z, nx, ny, nz, tries;
        bit  found;
        r = $urandom_range(99);
        found = 1'b0;
        if (r >= 50 && r < 78) begin
            for (tries = 0; tries < 20 && !found; tries++) begin
                pick_hot(x, y, z);
                found = eval_ok(x, y, z);
            end
        end else if (r >= 96) begin
            for (tries = 0; tries < 20 && !found; tries++) begin
                x = $urandom_range(31);
                y = $urandom_range(63);
                z = $urandom_range(31);
                found = eval_ok(x, y, z);
            end
        end
        if (found) begin
            send_cmd(vfc_pkg::CMD_EVAL, x, y, z, 1'($urandom_range(1)));
        end else if (r >= 78 && r < 88) begin
            send_cmd(vfc_pkg::CMD_WRITE, $urandom_range(31), $urandom_range(63),
                     $urandom_range(31), 1'($urandom_range(1)));
        end else if (r >= 88 && r < 93) begin
            send_cmd(vfc_pkg::CMD_CLEAR, $urandom_range(31), $urandom_range(63),
                     $urandom_range(31), 1'($urandom_range(1)));
        end else if (r >= 93 && r < 96) begin
            send_cmd(CMD_NONE, $urandom_range(31), $urandom_range(63), $urandom_range(31),
                     1'($urandom_range(1)));
        end else begin
            // neighborhood fill with random occupancy, then evaluate its center
            pick_hot(x, y, z);
            for (int k = 0; k < vfc_pkg::NUM_RD; k++) begin
                window_cell(k, x, y, z, nx, ny, nz);
                if (in_store(nx, ny, nz) && (!written[nx][ny][nz] || $urandom_range(1) != 0))
                    send_cmd(vfc_pkg::CMD_WRITE, nx, ny, nz,
                             (k == 0) ? ($urandom_range(3) != 0) : 1'($urandom_range(1)));
            end
            send_cmd(vfc_pkg::CMD_EVAL, x, y, z, 1'($urandom_range(1)));
        end
    endtask

    task automatic run_random(input int n_items);
        int stop_at;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
            random_step();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part
        send_cmd(vfc_pkg::CMD_CLEAR, 0, 0, 0, 1'b0);
        send_cmd(CMD_NONE, 31, 63, 31, 1'b1);
        send_cmd(vfc_pkg::CMD_WRITE, 31, 63, 31, 1'b1);      // outside the padded store
        send_cmd(vfc_pkg::CMD_WRITE, 20, 0, 5, 1'b1);
        send_cmd(vfc_pkg::CMD_WRITE, 5, 10, 24, 1'b1);
        // bottom layer: ring neighbor solid, bottom face always shown
        send_cmd(vfc_pkg::CMD_WRITE, 1, 0, 1, 1'b1);
        send_cmd(vfc_pkg::CMD_WRITE, 0, 0, 1, 1'b1);
        send_cmd(vfc_pkg::CMD_WRITE, 1, 0, 2, 1'b1);
        fill_unwritten(1, 0, 1);
        send_cmd(vfc_pkg::CMD_EVAL, 1, 0, 1, 1'b0);
        // top layer fully enclosed: only the top face
        send_cmd(vfc_pkg::CMD_WRITE, 16, 63, 16, 1'b1);
        send_cmd(vfc_pkg::CMD_WRITE, 15, 63, 16, 1'b1);
        send_cmd(vfc_pkg::CMD_WRITE, 17, 63, 16, 1'b1);
        send_cmd(vfc_pkg::CMD_WRITE, 16, 63, 15, 1'b1);
        send_cmd(vfc_pkg::CMD_WRITE, 16, 63, 17, 1'b1);
        send_cmd(vfc_pkg::CMD_WRITE, 16, 62, 16, 1'b1);
        send_cmd(vfc_pkg::CMD_EVAL, 16, 63, 16, 1'b1);
        // isolated voxel: all six faces
        send_cmd(vfc_pkg::CMD_WRITE, 8, 30, 8, 1'b1);
        fill_unwritten(8, 30, 8);
        send_cmd(vfc_pkg::CMD_EVAL, 8, 30, 8, 1'b0);
        // ring voxel, empty voxel and out-of-range evaluates give nothing
        fill_unwritten(0, 0, 1);
        send_cmd(vfc_pkg::CMD_EVAL, 0, 0, 1, 1'b1);
        fill_unwritten(2, 0, 1);
        send_cmd(vfc_pkg::CMD_EVAL, 2, 0, 1, 1'b1);
        send_cmd(vfc_pkg::CMD_EVAL, 31, 5, 31, 1'b0);
        // counter restarts after clear
        send_cmd(vfc_pkg::CMD_CLEAR, 31, 63, 31, 1'b1);
        send_cmd(vfc_pkg::CMD_EVAL, 8, 30, 8, 1'b0);
        send_cmd(vfc_pkg::CMD_WRITE, 8, 30, 8, 1'b0);
        send_cmd(vfc_pkg::CMD_EVAL, 8, 30, 8, 1'b1);
        send_cmd(vfc_pkg::CMD_WRITE, 8, 30, 8, 1'b1);
        wait_drained();

        tx_idle_pct = 15;
        rx_idle_pct = 52;
        run_random(140);
        wait_drained();

        tx_idle_pct = 52;
        rx_idle_pct = 15;
        run_random(130);
        wait_drained();

        // no idling; output held off at the start so the core backs up
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        fork
            begin
                hold_on <= 1'b1;
                repeat (HOLD_LEN) @(posedge i_clk);
                hold_on <= 1'b0;
            end
        join_none
        run_random(130);
        wait_drained();

        if (mesh.fail_count == 0 && mesh.pending_faces.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
